>>> rtl/sjsg_pkg.sv
// Shared types, constants and offset tables for the sub-pixel jitter generator.
`timescale 1ns / 1ps

package sjsg_pkg;

   // Sequence lengths: frame phase is taken modulo these before a table lookup
   localparam int unsigned PATTERN_LENGTH = 8;
   localparam int unsigned HALTON_LENGTH  = 16;

   localparam int unsigned PATTERN_LEN_SAFE = (PATTERN_LENGTH == 0) ? 1 : PATTERN_LENGTH;
   localparam int unsigned HALTON_LEN_SAFE  = (HALTON_LENGTH == 0) ? 1 : HALTON_LENGTH;

   // Q0.15 one half, and the R2 increments 1/g and 1/g^2 in Q0.32
   localparam int          Q15_HALF   = 16384;
   localparam logic [31:0] R2_STEP_X  = 32'd3242174889;
   localparam logic [31:0] R2_STEP_Y  = 32'd2447445413;

   localparam int unsigned PHASE_WIDTH  = 4;
   localparam int unsigned PHASE_COUNT  = 16;
   localparam int unsigned OFFSET_WIDTH = 15;
   localparam int unsigned ACCUM_WIDTH  = 32;

   typedef enum logic [1:0] {
      MODE_TABLE  = 2'd0,
      MODE_HALTON = 2'd1,
      MODE_R2     = 2'd2,
      MODE_NONE   = 2'd3
   } jitter_mode_type;

   typedef logic signed [OFFSET_WIDTH-1:0] offset_type;
   typedef offset_type offset_table_type [PHASE_COUNT];

   // Sequence state seen by the offset logic
   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic [ACCUM_WIDTH-1:0] accum_x;
      logic [ACCUM_WIDTH-1:0] accum_y;
   } jitter_state_type;

   // Eight-entry sample pattern
   localparam offset_type PATTERN_X [8] = '{
      15'sd2048,   -15'sd2048, 15'sd10240, -15'sd6144,
      -15'sd10240, -15'sd14336, 15'sd6144, 15'sd14336
   };
   localparam offset_type PATTERN_Y [8] = '{
      -15'sd6144,  15'sd6144,  15'sd2048,  -15'sd10240,
      15'sd10240,  15'sd2048,  15'sd14336, -15'sd14336
   };

   // Pattern entry for each frame phase, wrapping at the pattern length
   function automatic offset_table_type build_pattern(input bit use_y);
      offset_table_type tbl;
      int unsigned      c;
      c = 0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         tbl[p] = use_y ? PATTERN_Y[c & 7] : PATTERN_X[c & 7];
         c = (c + 1 == PATTERN_LEN_SAFE) ? 0 : c + 1;
      end
      return tbl;
   endfunction

   // Base-2 radical inverse of idx, minus one half
   function automatic offset_type halton2_value(input int unsigned idx);
      int unsigned rev;
      int          val;
      rev = 0;
      for (int i = 0; i < 5; i++) begin
         rev = (rev << 1) | ((idx >> i) & 1);
      end
      val = int'(rev * 1024) - Q15_HALF;
      return OFFSET_WIDTH'(val);
   endfunction

   // Base-3 radical inverse of idx as N/27, rounded, minus one half
   function automatic offset_type halton3_value(input int unsigned idx);
      int unsigned n;
      int unsigned v;
      int          val;
      n = 0;
      v = idx;
      for (int i = 0; i < 3; i++) begin
         n = n * 3 + (v % 3);
         v = v / 3;
      end
      val = int'((n * 32768 + 13) / 27) - Q15_HALF;
      return OFFSET_WIDTH'(val);
   endfunction

   // Halton value for each frame phase, index running 1..HALTON_LENGTH
   function automatic offset_table_type build_halton(input bit use_y);
      offset_table_type tbl;
      int unsigned      c;
      c = 0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         tbl[p] = use_y ? halton3_value(c + 1) : halton2_value(c + 1);
         c = (c + 1 == HALTON_LEN_SAFE) ? 0 : c + 1;
      end
      return tbl;
   endfunction

   localparam offset_table_type PATTERN_X_BY_PHASE = build_pattern(1'b0);
   localparam offset_table_type PATTERN_Y_BY_PHASE = build_pattern(1'b1);
   localparam offset_table_type HALTON_X_BY_PHASE  = build_halton(1'b0);
   localparam offset_table_type HALTON_Y_BY_PHASE  = build_halton(1'b1);

endpackage

>>> rtl/sjsg_offset_gen.sv
// Offset selection: table, Halton, R2 or zero, picked by the jitter mode.
`timescale 1ns / 1ps

module sjsg_offset_gen (
   input  sjsg_pkg::jitter_mode_type  mode,
   input  sjsg_pkg::jitter_state_type state,
   output sjsg_pkg::offset_type       offset_x,
   output sjsg_pkg::offset_type       offset_y
);
   import sjsg_pkg::*;

   // R2 output: top 15 accumulator bits minus one half flips the top bit
   always_comb begin
      case (mode)
         MODE_TABLE: begin
            offset_x = PATTERN_X_BY_PHASE[state.phase];
            offset_y = PATTERN_Y_BY_PHASE[state.phase];
         end
         MODE_HALTON: begin
            offset_x = HALTON_X_BY_PHASE[state.phase];
            offset_y = HALTON_Y_BY_PHASE[state.phase];
         end
         MODE_R2: begin
            offset_x = {~state.accum_x[ACCUM_WIDTH-1], state.accum_x[ACCUM_WIDTH-2 -: 14]};
            offset_y = {~state.accum_y[ACCUM_WIDTH-1], state.accum_y[ACCUM_WIDTH-2 -: 14]};
         end
         default: begin
            offset_x = '0;
            offset_y = '0;
         end
      endcase
   end

endmodule

>>> rtl/sjsg_seq_state.sv
// Frame phase counter and R2 accumulators, advanced on frame end.
`timescale 1ns / 1ps

module sjsg_seq_state (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       advance_frame,
   input  sjsg_pkg::jitter_mode_type  mode,
   output sjsg_pkg::jitter_state_type state
);
   import sjsg_pkg::*;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [ACCUM_WIDTH-1:0] accum_x_ff, accum_x_in;
   logic [ACCUM_WIDTH-1:0] accum_y_ff, accum_y_in;

   // Advance phase on frame end; step R2 only while in R2 mode
   always_comb begin
      phase_in   = phase_ff;
      accum_x_in = accum_x_ff;
      accum_y_in = accum_y_ff;
      if (step && advance_frame) begin
         phase_in = phase_ff + PHASE_WIDTH'(1);
         if (mode == MODE_R2) begin
            accum_x_in = accum_x_ff + R2_STEP_X;
            accum_y_in = accum_y_ff + R2_STEP_Y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         accum_x_ff <= '0;
         accum_y_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         accum_x_ff <= accum_x_in;
         accum_y_ff <= accum_y_in;
      end
   end

   assign state.phase   = phase_ff;
   assign state.accum_x = accum_x_ff;
   assign state.accum_y = accum_y_ff;

endmodule

>>> rtl/subpixel_jitter_sequence_generator.sv
// Top level of the sub-pixel jitter generator: request stage, result stage, mode register.
//
// Usage:
//   req channel: one request per beat, req_tdata[0] = advance_frame. Each request
//     returns the jitter offset of the current frame; advance_frame = 1 then ends
//     that frame (frame phase steps, R2 accumulators step when in R2 mode).
//   rsp channel: one result per request, in order. rsp_tdata holds offset_x in
//     bits 14:0 and offset_y in bits 29:15, signed Q0.15 pixels.
//   csr port: csr_wr_en writes csr_wr_data into the jitter mode (0 pattern table,
//     1 Halton 2/3, 2 R2 recurrence, 3 no jitter). Write only while idle.
// Path: a request passes the request register, then the result register. Throughput:
//   one request per cycle while rsp_tready is high, set by the combinational table
//   lookup and the two 32-bit accumulator adders.
// Reset: synchronous; clears the mode to the pattern table, the frame phase,
//   the R2 accumulators and both stage valids.
// Stall: while rsp_tready is low the result holds; one more request is taken
//   into the request register, then req_tready drops until the result leaves.
`timescale 1ns / 1ps

module subpixel_jitter_sequence_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] advance_frame, [7:1] zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] offset_x, [29:15] offset_y, [31:30] zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import sjsg_pkg::*;

   jitter_mode_type  mode_ff;
   logic             req_valid_ff, req_valid_in;
   logic             req_adv_ff, req_adv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   offset_type       rsp_x_ff, rsp_x_in;
   offset_type       rsp_y_ff, rsp_y_in;
   logic             step;
   jitter_state_type state;
   offset_type       calc_x;
   offset_type       calc_y;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TABLE;
      end else if (csr_wr_en) begin
         mode_ff <= jitter_mode_type'(csr_wr_data);
      end
   end

   // Move the held request into the result stage when that stage is free
   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;

   sjsg_seq_state u_state (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .advance_frame (req_adv_ff),
      .mode          (mode_ff),
      .state         (state)
   );

   sjsg_offset_gen u_offset (
      .mode     (mode_ff),
      .state    (state),
      .offset_x (calc_x),
      .offset_y (calc_y)
   );

   // Next values of both stages
   always_comb begin
      req_valid_in = req_valid_ff;
      req_adv_in   = req_adv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         req_valid_in = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_x_in     = calc_x;
         rsp_y_in     = calc_y;
      end
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
         req_adv_in   = req_tdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_adv_ff <= req_adv_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_y_ff, rsp_x_ff};

endmodule

>>> rtl/sjsg_checker.sv
// Port-level checker for the jitter generator, bound to the top level.
`timescale 1ns / 1ps

module sjsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   logic [1:0] pending_ff, pending_in;

   // Track requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Stalled result holds its value
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // No result without a request behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("result without request");

   // Both stages full and stalled: no new request
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((pending_ff == 2'd2) && !rsp_tready) |-> !req_tready)
      else $error("request taken while full");

endmodule

bind subpixel_jitter_sequence_generator sjsg_checker u_sjsg_checker (.*);
